### hdl/sbi_pkg.sv
// Package with shared constants of the segment/box intersection block.
`timescale 1ns / 1ps
package sbi_pkg;

    // Default coordinate format: signed Q16.16.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOX_BOTTOM = 2'd1;
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

endpackage

### hdl/sbi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module sbi_div #(
    parameter int QW = sbi_pkg::COORD_BITS + 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [2*QW-1:0]   num,
    input  logic [QW-1:0]     den,
    output logic [QW-1:0]     quo
);

    // The caller guarantees that the upper half of num is below den,
    // so the quotient fits in QW bits.
    logic [QW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [QW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [QW:0]   trial;
            logic [QW:0]   diff;
            logic          ge;
            logic [QW-1:0] rem_next;
            logic [QW-1:0] low_next;
            logic [QW-1:0] quo_next;

            if (s == 0) begin : g_first
                assign rem_in = num[2*QW-1:QW];
                assign low_in = num[QW-1:0];
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            always_comb
            begin
                trial    = {rem_in, low_in[QW-1]};
                diff     = trial - {1'b0, den_in};
                ge       = (trial >= {1'b0, den_in});
                rem_next = ge ? diff[QW-1:0] : trial[QW-1:0];
                low_next = {low_in[QW-2:0], 1'b0};
                quo_next = {quo_in[QW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    low_reg[s] <= low_next;
                    den_reg[s] <= den_in;
                    quo_reg[s] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

### hdl/segment_box_intersection_top.sv
// Top level of the segment / axis-aligned box intersection pipeline.
`timescale 1ns / 1ps
// The block takes one line segment per item (two endpoints, signed fixed
// point) and reports where it crosses the edges of a configured axis-aligned
// box: up to two points, tested in the order left, right, bottom, top, each
// kept when it lies inside the closed box and inside the segment's bounding
// span. Unused point fields read as zero. The pipeline accepts one item every
// cycle while the output is not stalled; its result passes through the input,
// delta, product, divider, crossing and output registers. The four parallel
// restoring dividers resolve one quotient bit per stage. A stall on
// the output freezes the whole pipeline, so nothing is lost or repeated.
// Box registers must only be written while no item is in flight.
module segment_box_intersection_top #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS,
    parameter int FRAC_BITS  = sbi_pkg::FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [COORD_BITS-1:0]        cfg_wdata,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   hit_count,
    output logic signed [COORD_BITS-1:0] first_x,
    output logic signed [COORD_BITS-1:0] first_y,
    output logic signed [COORD_BITS-1:0] second_x,
    output logic signed [COORD_BITS-1:0] second_y
);

    // CW holds any sum of two coordinates with room for a sign, MW holds
    // the magnitude of any coordinate difference.
    localparam int CW = COORD_BITS + 2;
    localparam int MW = COORD_BITS + 1;
    localparam int PW = 2 * MW;

    typedef struct packed {
        logic                 ok;   // edge applies and lies within the span
        logic                 neg;  // sign of the offset along the other axis
        logic signed [CW-1:0] sb;   // start on the other axis
        logic signed [CW-1:0] e;    // edge coordinate
    } edge_side_t;

    typedef struct packed {
        logic signed [CW-1:0] xlo;
        logic signed [CW-1:0] xhi;
        logic signed [CW-1:0] ylo;
        logic signed [CW-1:0] yhi;
    } span_t;

    typedef struct packed {
        span_t            span;
        edge_side_t [3:0] edges;
    } side_t;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] box_left_reg;
    logic signed [COORD_BITS-1:0] box_bottom_reg;
    logic [COORD_BITS-2:0]        box_width_reg;
    logic [COORD_BITS-2:0]        box_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_bottom_reg <= '0;
            box_width_reg  <= (COORD_BITS-1)'(1) << FRAC_BITS;
            box_height_reg <= (COORD_BITS-1)'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sbi_pkg::REG_BOX_LEFT:   box_left_reg   <= cfg_wdata;
                sbi_pkg::REG_BOX_BOTTOM: box_bottom_reg <= cfg_wdata;
                sbi_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_wdata[COORD_BITS-2:0];
                sbi_pkg::REG_BOX_HEIGHT: box_height_reg <= cfg_wdata[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    // Box edges at full precision; the user must keep the registers stable while items flow (not enforced here).
    logic signed [CW-1:0] edge_l;
    logic signed [CW-1:0] edge_r;
    logic signed [CW-1:0] edge_b;
    logic signed [CW-1:0] edge_t;

    assign edge_l = CW'(box_left_reg);
    assign edge_b = CW'(box_bottom_reg);
    assign edge_r = edge_l + $signed(CW'({1'b0, box_width_reg}));
    assign edge_t = edge_b + $signed(CW'({1'b0, box_height_reg}));

    // Whole pipeline moves together whenever the output slot can take a result.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage 1: input register.
    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] s1_sx_reg;
    logic signed [COORD_BITS-1:0] s1_sy_reg;
    logic signed [COORD_BITS-1:0] s1_ex_reg;
    logic signed [COORD_BITS-1:0] s1_ey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sx_reg <= start_x;
            s1_sy_reg <= start_y;
            s1_ex_reg <= end_x;
            s1_ey_reg <= end_y;
        end
    end

    // Stage 2: deltas, span, and per-edge magnitudes and signs.
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    span_t                span_next;
    edge_side_t [3:0]     edges_next;
    logic [MW-1:0]        mag_d_next   [4];
    logic [MW-1:0]        mag_b_next   [4];
    logic [MW-1:0]        mag_off_next [4];

    always_comb
    begin
        logic signed [CW-1:0] sa;
        logic signed [CW-1:0] da;
        logic signed [CW-1:0] db;
        logic signed [CW-1:0] off;
        logic signed [CW-1:0] neg_da;
        logic signed [CW-1:0] neg_db;
        logic signed [CW-1:0] neg_off;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;

        sx = CW'(s1_sx_reg);
        sy = CW'(s1_sy_reg);
        ex = CW'(s1_ex_reg);
        ey = CW'(s1_ey_reg);
        dx = ex - sx;
        dy = ey - sy;

        span_next.xlo = (sx < ex) ? sx : ex;
        span_next.xhi = (sx < ex) ? ex : sx;
        span_next.ylo = (sy < ey) ? sy : ey;
        span_next.yhi = (sy < ey) ? ey : sy;

        for (int k = 0; k < 4; k++)
        begin
            if (k < 2)
            begin
                sa = sx;
                da = dx;
                db = dy;
                lo = span_next.xlo;
                hi = span_next.xhi;
                edges_next[k].sb = sy;
                edges_next[k].e  = (k == 0) ? edge_l : edge_r;
            end
            else
            begin
                sa = sy;
                da = dy;
                db = dx;
                lo = span_next.ylo;
                hi = span_next.yhi;
                edges_next[k].sb = sx;
                edges_next[k].e  = (k == 2) ? edge_b : edge_t;
            end
            off     = edges_next[k].e - sa;
            neg_da  = -da;
            neg_db  = -db;
            neg_off = -off;
            mag_d_next[k]   = da[CW-1]  ? neg_da[MW-1:0]  : da[MW-1:0];
            mag_b_next[k]   = db[CW-1]  ? neg_db[MW-1:0]  : db[MW-1:0];
            mag_off_next[k] = off[CW-1] ? neg_off[MW-1:0] : off[MW-1:0];
            edges_next[k].neg = da[CW-1] ^ db[CW-1] ^ off[CW-1];
            edges_next[k].ok  = (da != '0) && (edges_next[k].e >= lo) &&
                                (edges_next[k].e <= hi);
        end
    end

    logic          s2_valid_reg;
    span_t         s2_span_reg;
    edge_side_t [3:0] s2_edges_reg;
    logic [MW-1:0] s2_mag_d_reg   [4];
    logic [MW-1:0] s2_mag_b_reg   [4];
    logic [MW-1:0] s2_mag_off_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_span_reg  <= span_next;
            s2_edges_reg <= edges_next;
            s2_mag_d_reg   <= mag_d_next;
            s2_mag_b_reg   <= mag_b_next;
            s2_mag_off_reg <= mag_off_next;
        end
    end

    // Stage 3: exact products, one multiplier per edge.
    logic          s3_valid_reg;
    span_t         s3_span_reg;
    edge_side_t [3:0] s3_edges_reg;
    logic [MW-1:0] s3_mag_d_reg [4];
    logic [PW-1:0] s3_prod_reg  [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_span_reg  <= s2_span_reg;
            s3_edges_reg <= s2_edges_reg;
            s3_mag_d_reg <= s2_mag_d_reg;
            for (int k = 0; k < 4; k++)
            begin
                s3_prod_reg[k] <= PW'(s2_mag_b_reg[k]) * PW'(s2_mag_off_reg[k]);
            end
        end
    end

    // Dividers and the side line that travels alongside them.
    logic [MW-1:0] quo [4];

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_div
            sbi_div #(
                .QW (MW)
            ) u_div (
                .clk (clk),
                .en  (en),
                .num (s3_prod_reg[g]),
                .den (s3_mag_d_reg[g]),
                .quo (quo[g])
            );
        end
    endgenerate

    side_t         side_reg [MW];
    logic [MW-1:0] side_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            side_valid_reg <= '0;
        end
        else if (en)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            side_valid_reg <= {side_valid_reg[MW-2:0], s3_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].span  <= s3_span_reg;
            side_reg[0].edges <= s3_edges_reg;
            for (int s = 1; s < MW; s++)
            begin
                side_reg[s].span  <= side_reg[s-1].span;
                side_reg[s].edges <= side_reg[s-1].edges;
            end
        end
    end

    // Stage after the dividers: crossing points per edge.
    logic                 sp_valid_reg;
    span_t                sp_span_reg;
    logic [3:0]           sp_ok_reg;
    logic signed [CW-1:0] sp_x_reg [4];
    logic signed [CW-1:0] sp_y_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sp_valid_reg <= side_valid_reg[MW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] qext;
        logic signed [CW-1:0] other;
        if (en)
        begin
            sp_span_reg <= side_reg[MW-1].span;
            for (int k = 0; k < 4; k++)
            begin
                qext  = $signed(CW'({1'b0, quo[k]}));
                other = side_reg[MW-1].edges[k].neg ?
                        side_reg[MW-1].edges[k].sb - qext :
                        side_reg[MW-1].edges[k].sb + qext;
                sp_ok_reg[k] <= side_reg[MW-1].edges[k].ok;
                if (k < 2)
                begin
                    sp_x_reg[k] <= side_reg[MW-1].edges[k].e;
                    sp_y_reg[k] <= other;
                end
                else
                begin
                    sp_x_reg[k] <= other;
                    sp_y_reg[k] <= side_reg[MW-1].edges[k].e;
                end
            end
        end
    end

    // Final stage: keep test and selection of the first two kept points.
    logic [1:0]                   count_next;
    logic signed [COORD_BITS-1:0] first_x_next;
    logic signed [COORD_BITS-1:0] first_y_next;
    logic signed [COORD_BITS-1:0] second_x_next;
    logic signed [COORD_BITS-1:0] second_y_next;

    always_comb
    begin
        logic keep;
        count_next    = '0;
        first_x_next  = '0;
        first_y_next  = '0;
        second_x_next = '0;
        second_y_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            keep = sp_ok_reg[k] &&
                   (sp_x_reg[k] >= edge_l) && (sp_x_reg[k] <= edge_r) &&
                   (sp_y_reg[k] >= edge_b) && (sp_y_reg[k] <= edge_t) &&
                   (sp_x_reg[k] >= sp_span_reg.xlo) && (sp_x_reg[k] <= sp_span_reg.xhi) &&
                   (sp_y_reg[k] >= sp_span_reg.ylo) && (sp_y_reg[k] <= sp_span_reg.yhi);
            if (keep && count_next == 2'd0)
            begin
                first_x_next = sp_x_reg[k][COORD_BITS-1:0];
                first_y_next = sp_y_reg[k][COORD_BITS-1:0];
                count_next   = 2'd1;
            end
            else if (keep && count_next == 2'd1)
            begin
                second_x_next = sp_x_reg[k][COORD_BITS-1:0];
                second_y_next = sp_y_reg[k][COORD_BITS-1:0];
                count_next    = 2'd2;
            end
        end
    end

    logic [1:0]                   hit_count_reg;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic signed [COORD_BITS-1:0] second_x_reg;
    logic signed [COORD_BITS-1:0] second_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_count_reg <= count_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            second_x_reg  <= second_x_next;
            second_y_reg  <= second_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_count = hit_count_reg;
    assign first_x   = first_x_reg;
    assign first_y   = first_y_reg;
    assign second_x  = second_x_reg;
    assign second_y  = second_y_reg;

endmodule
